@@ rtl/smf_pkg.sv @@
`default_nettype none

package smf_pkg;

  // Window length in samples, from 1 to 255.
  localparam int unsigned WINDOW_C = 71;

  // Width of one sample.
  localparam int unsigned SAMPLE_W = 16;

  // Number of stored history samples; one entry is kept even for a window of one.
  localparam int unsigned HIST_N = WINDOW_C - 1;
  localparam int unsigned HIST_DEPTH = (HIST_N > 0) ? HIST_N : 1;
  localparam bit HAS_HIST = (HIST_N > 0);

  // Rank of the median in the sorted window, counted from zero.
  localparam int unsigned MID = WINDOW_C / 2;

  // Address width of the history memories and width of the pass counters.
  localparam int unsigned AW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(WINDOW_C + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OLD,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } state_e;

  // Commands from the sequencer to the sorted-history datapath.
  typedef struct packed {
    logic          start;    // load the carry with the new sample, clear pass state
    logic          elem;     // read data of the sorted memory is valid this cycle
    logic          flush;    // emit the carry as the last element of the pass
    logic          rd_en;    // issue a read of the sorted memory
    logic [AW-1:0] rd_addr;  // address of that read
  } smf_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/smf_ring.sv @@
`default_nettype none

// Circular buffer of the history in arrival order. It supplies the oldest
// sample, which leaves the window at the end of each pass.
module smf_ring (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic             wr_en_i,
  input  wire smf_pkg::sample_t wr_data_i,
  output smf_pkg::sample_t      old_o
);
  import smf_pkg::*;

  sample_t       mem_q [HIST_DEPTH];
  sample_t       rdata_q;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          wrapped_q, wrapped_d;

  // Single-port style memory with a registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[ptr_q] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[ptr_q];
    end
  end

  // The write pointer also marks the oldest entry; entries count as zero
  // until the buffer has been filled once.
  always_comb begin
    ptr_d     = ptr_q;
    wrapped_d = wrapped_q;
    if (wr_en_i) begin
      if (ptr_q == AW'(HIST_DEPTH - 1)) begin
        ptr_d     = '0;
        wrapped_d = 1'b1;
      end else begin
        ptr_d = ptr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      wrapped_q <= 1'b0;
    end else begin
      ptr_q     <= ptr_d;
      wrapped_q <= wrapped_d;
    end
  end

  assign old_o = wrapped_q ? rdata_q : '0;

endmodule

`default_nettype wire

@@ rtl/smf_sorted.sv @@
`default_nettype none

// Sorted copy of the history. One pass streams it out in ascending order,
// merges the new sample in through a carry register, picks the median from
// the merged stream and writes the stream back without the oldest sample.
module smf_sorted (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire smf_pkg::smf_ctrl_t ctrl_i,
  input  wire smf_pkg::sample_t   new_i,
  input  wire smf_pkg::sample_t   old_i,
  output smf_pkg::sample_t        med_o
);
  import smf_pkg::*;

  sample_t       mem_q [HIST_DEPTH];
  sample_t       rdata_q;
  logic          primed_q;
  sample_t       carry_q, carry_d;
  logic          del_q, del_d;
  logic [CW-1:0] wr_q, wr_d;
  logic [CW-1:0] em_q, em_d;
  sample_t       med_q, med_d;

  sample_t       elem;
  sample_t       emit_val;
  logic          emit_vld;
  logic          wr_en;

  // Until the first pass has written it, the memory reads as all zero.
  assign elem = primed_q ? rdata_q : '0;

  // Merge step: the smaller value leaves, the larger one stays in the carry.
  always_comb begin
    carry_d  = carry_q;
    emit_val = carry_q;
    emit_vld = 1'b0;
    if (ctrl_i.start) begin
      carry_d = new_i;
    end else if (ctrl_i.elem) begin
      emit_vld = 1'b1;
      if (elem < carry_q) begin
        emit_val = elem;
      end else begin
        emit_val = carry_q;
        carry_d  = elem;
      end
    end else if (ctrl_i.flush) begin
      emit_vld = 1'b1;
      emit_val = carry_q;
    end
  end

  // Median pick and removal of the first copy of the oldest sample.
  always_comb begin
    del_d = del_q;
    wr_d  = wr_q;
    em_d  = em_q;
    med_d = med_q;
    wr_en = 1'b0;
    if (ctrl_i.start) begin
      del_d = 1'b0;
      wr_d  = '0;
      em_d  = '0;
    end else if (emit_vld) begin
      em_d = em_q + CW'(1);
      if (em_q == CW'(MID)) begin
        med_d = emit_val;
      end
      if (HAS_HIST && !del_q && (emit_val == old_i)) begin
        del_d = 1'b1;
      end else begin
        wr_en = 1'b1;
        wr_d  = wr_q + CW'(1);
      end
    end
  end

  // Sorted memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en && HAS_HIST) begin
      mem_q[wr_q[AW-1:0]] <= emit_val;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[ctrl_i.rd_addr];
    end
  end

  // Pass payload registers.
  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    med_q   <= med_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
      del_q    <= 1'b0;
      wr_q     <= '0;
      em_q     <= '0;
    end else begin
      if (ctrl_i.flush) begin
        primed_q <= 1'b1;
      end
      del_q <= del_d;
      wr_q  <= wr_d;
      em_q  <= em_d;
    end
  end

  assign med_o = med_q;

endmodule

`default_nettype wire

@@ rtl/sliding_window_median_filter_core.sv @@
`default_nettype none

// Running median filter over a window of WINDOW_C (71) signed 16-bit samples:
// each accepted sample yields the element of rank WINDOW_C/2 of the sorted
// window made of the previous WINDOW_C-1 samples and the new one (the upper
// median for an even window); history starts as all zeros after reset, with
// no clearing pass, so a sample is taken in the first cycle after reset.
// After acceptance, the oldest sample is fetched from the arrival-order memory,
// then each entry of the sorted history memory is walked through its single
// read port, then a flush step runs, and the median is loaded into the output
// register once it is free or being read. One sample is processed at a
// time; the next is accepted as soon as the previous median has moved to the
// output register.
module sliding_window_median_filter_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic signed [15:0]   s_axis_tdata,   // [15:0] sample
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic signed [15:0]        m_axis_tdata    // [15:0] median
);
  import smf_pkg::*;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  sample_t       new_q, new_d;
  logic          out_vld_q, out_vld_d;
  sample_t       out_q, out_d;

  smf_ctrl_t     ctrl;
  logic          ring_rd;
  logic          ring_wr;
  sample_t       old_val;
  sample_t       med;

  // Sequencer for one pass over the sorted history.
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    new_d         = new_q;
    out_vld_d     = out_vld_q;
    out_d         = out_q;
    s_axis_tready = 1'b0;
    ring_rd       = 1'b0;
    ring_wr       = 1'b0;
    ctrl          = '0;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          new_d   = s_axis_tdata;
          ring_rd = 1'b1;
          state_d = ST_OLD;
        end
      end
      ST_OLD: begin
        ctrl.start = 1'b1;
        cnt_d      = '0;
        if (HAS_HIST) begin
          ctrl.rd_en   = 1'b1;
          ctrl.rd_addr = '0;
          state_d      = ST_SCAN;
        end else begin
          state_d = ST_FLUSH;
        end
      end
      ST_SCAN: begin
        ctrl.elem = 1'b1;
        if (cnt_q == CW'(HIST_DEPTH - 1)) begin
          state_d = ST_FLUSH;
        end else begin
          cnt_d        = cnt_q + CW'(1);
          ctrl.rd_en   = 1'b1;
          ctrl.rd_addr = cnt_d[AW-1:0];
        end
      end
      ST_FLUSH: begin
        ctrl.flush = 1'b1;
        ring_wr    = HAS_HIST;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          out_d     = med;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Sample and result payload registers.
  always_ff @(posedge clk_i) begin
    new_q <= new_d;
    out_q <= out_d;
  end

  smf_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (ring_rd),
    .wr_en_i   (ring_wr),
    .wr_data_i (new_q),
    .old_o     (old_val)
  );

  smf_sorted u_sorted (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .new_i  (new_q),
    .old_i  (old_val),
    .med_o  (med)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire
